>>> rtl/assert_macros.svh
// assertion macros used by the scanner core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge, held off during reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the next edge, also active during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/jfhs_pkg.sv
// types, codes and helper functions for the jpeg frame header scanner
package jfhs_pkg;

  // parser phases
  typedef enum logic [3:0] {
    PH_SIG0   = 4'd0,
    PH_SIG1   = 4'd1,
    PH_PREFIX = 4'd2,
    PH_CODE   = 4'd3,
    PH_LENHI  = 4'd4,
    PH_LENLO  = 4'd5,
    PH_SKIP   = 4'd6,
    PH_FRAME  = 4'd7,
    PH_APPSIG = 4'd8
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIG   = 3'd1,
    ST_BAD_MRK   = 3'd2,
    ST_NO_FRAME  = 3'd3,
    ST_BAD_COMP  = 3'd4
  } status_t;

  // color space codes
  localparam logic [1:0] CS_GRAY = 2'd0;
  localparam logic [1:0] CS_RGB  = 2'd1;
  localparam logic [1:0] CS_CMYK = 2'd2;

  // marker bytes
  localparam logic [7:0] BYTE_FF    = 8'hff;
  localparam logic [7:0] BYTE_SOI   = 8'hd8;
  localparam logic [7:0] SOF_FIRST  = 8'hc0;
  localparam logic [7:0] SOF_LAST   = 8'hcf;
  localparam logic [7:0] MRK_DHT    = 8'hc4;
  localparam logic [7:0] MRK_JPG    = 8'hc8;
  localparam logic [7:0] MRK_DAC    = 8'hcc;
  localparam logic [7:0] MRK_APP14  = 8'hee;

  localparam logic [2:0] SIG_LAST_IDX = 3'd4;

  // one result transaction
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  bits_per_component;
    logic [7:0]  component_count;
    logic [1:0]  color_space;
    logic        invert_decode;
  } result_t;

  // start-of-frame marker test
  function automatic logic is_sof(input logic [7:0] code);
    is_sof = (code >= SOF_FIRST) && (code <= SOF_LAST) &&
             (code != MRK_DHT) && (code != MRK_JPG) && (code != MRK_DAC);
  endfunction

  // five-byte app14 signature, ascii letters
  function automatic logic [7:0] app14_sig(input logic [2:0] idx);
    unique case (idx)
      3'd0:    app14_sig = 8'h41;
      3'd1:    app14_sig = 8'h64;
      3'd2:    app14_sig = 8'h6f;
      3'd3:    app14_sig = 8'h62;
      3'd4:    app14_sig = 8'h65;
      default: app14_sig = 8'h41;
    endcase
  endfunction

endpackage

>>> rtl/jfhs_parser.sv
// marker segment parser: per-byte state update and result decode
module jfhs_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_acc,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  logic                last_byte,
  output jfhs_pkg::result_t   res
);

  jfhs_pkg::phase_t phase_r, phase_nxt, cur_phase;
  logic [15:0] skip_r, skip_nxt, cur_skip;
  logic [2:0]  fidx_r, fidx_nxt, cur_fidx;
  logic [7:0]  lenhi_r, lenhi_nxt, cur_lenhi;
  logic [7:0]  code_r, code_nxt, cur_code;
  logic        seen_r, seen_nxt, cur_seen;
  logic        match_r, match_nxt, cur_match;
  logic [15:0] height_r, height_nxt, cur_height;
  logic [15:0] width_r, width_nxt, cur_width;
  logic [7:0]  prec_r, prec_nxt, cur_prec;
  logic        done_r, done_nxt, cur_done;

  logic [15:0] seg_len;
  logic [15:0] app_rest;
  logic [15:0] skip_dec;
  logic        sig_ok;

  // a first byte restarts from the reset state
  always_comb begin
    if (first_byte) begin
      cur_phase  = jfhs_pkg::PH_SIG0;
      cur_skip   = '0;
      cur_fidx   = '0;
      cur_lenhi  = '0;
      cur_code   = '0;
      cur_seen   = 1'b0;
      cur_match  = 1'b0;
      cur_height = '0;
      cur_width  = '0;
      cur_prec   = '0;
      cur_done   = 1'b0;
    end else begin
      cur_phase  = phase_r;
      cur_skip   = skip_r;
      cur_fidx   = fidx_r;
      cur_lenhi  = lenhi_r;
      cur_code   = code_r;
      cur_seen   = seen_r;
      cur_match  = match_r;
      cur_height = height_r;
      cur_width  = width_r;
      cur_prec   = prec_r;
      cur_done   = done_r;
    end
  end

  assign seg_len  = {cur_lenhi, data_byte} - 16'd2;
  assign app_rest = cur_skip - 16'd5;
  assign skip_dec = cur_skip - 16'd1;
  assign sig_ok   = cur_match && (data_byte == jfhs_pkg::app14_sig(cur_fidx));

  // next state
  always_comb begin
    phase_nxt  = cur_phase;
    skip_nxt   = cur_skip;
    fidx_nxt   = cur_fidx;
    lenhi_nxt  = cur_lenhi;
    code_nxt   = cur_code;
    seen_nxt   = cur_seen;
    match_nxt  = cur_match;
    height_nxt = cur_height;
    width_nxt  = cur_width;
    prec_nxt   = cur_prec;
    done_nxt   = cur_done || res.valid;
    if (!cur_done) begin
      unique case (cur_phase)
        jfhs_pkg::PH_SIG0: begin
          if (data_byte == jfhs_pkg::BYTE_FF) phase_nxt = jfhs_pkg::PH_SIG1;
        end
        jfhs_pkg::PH_SIG1: begin
          if (data_byte == jfhs_pkg::BYTE_SOI) phase_nxt = jfhs_pkg::PH_PREFIX;
        end
        jfhs_pkg::PH_PREFIX: begin
          if (data_byte == jfhs_pkg::BYTE_FF) phase_nxt = jfhs_pkg::PH_CODE;
        end
        jfhs_pkg::PH_CODE: begin
          if (data_byte != jfhs_pkg::BYTE_FF) begin
            code_nxt  = data_byte;
            phase_nxt = jfhs_pkg::PH_LENHI;
          end
        end
        jfhs_pkg::PH_LENHI: begin
          lenhi_nxt = data_byte;
          phase_nxt = jfhs_pkg::PH_LENLO;
        end
        jfhs_pkg::PH_LENLO: begin
          skip_nxt = seg_len;
          fidx_nxt = '0;
          priority if (jfhs_pkg::is_sof(cur_code)) begin
            phase_nxt = jfhs_pkg::PH_FRAME;
          end else if (cur_code == jfhs_pkg::MRK_APP14) begin
            match_nxt = 1'b1;
            phase_nxt = jfhs_pkg::PH_APPSIG;
          end else begin
            phase_nxt = (seg_len == '0) ? jfhs_pkg::PH_PREFIX : jfhs_pkg::PH_SKIP;
          end
        end
        jfhs_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) phase_nxt = jfhs_pkg::PH_PREFIX;
        end
        jfhs_pkg::PH_APPSIG: begin
          match_nxt = sig_ok;
          fidx_nxt  = cur_fidx + 3'd1;
          if (cur_fidx == jfhs_pkg::SIG_LAST_IDX) begin
            seen_nxt  = cur_seen || sig_ok;
            fidx_nxt  = '0;
            skip_nxt  = app_rest;
            phase_nxt = (app_rest == '0) ? jfhs_pkg::PH_PREFIX : jfhs_pkg::PH_SKIP;
          end
        end
        jfhs_pkg::PH_FRAME: begin
          unique case (cur_fidx)
            3'd0:       prec_nxt   = data_byte;
            3'd1, 3'd2: height_nxt = {cur_height[7:0], data_byte};
            3'd3, 3'd4: width_nxt  = {cur_width[7:0], data_byte};
            default:    ;
          endcase
          fidx_nxt = cur_fidx + 3'd1;
        end
        default: phase_nxt = jfhs_pkg::PH_SIG0;
      endcase
    end
  end

  // result decode
  always_comb begin
    res = '0;
    res.status = jfhs_pkg::ST_OK;
    if (byte_acc && !cur_done) begin
      unique case (cur_phase)
        jfhs_pkg::PH_SIG0: begin
          if (data_byte != jfhs_pkg::BYTE_FF) begin
            res.valid  = 1'b1;
            res.status = jfhs_pkg::ST_BAD_SIG;
          end
        end
        jfhs_pkg::PH_SIG1: begin
          if (data_byte != jfhs_pkg::BYTE_SOI) begin
            res.valid  = 1'b1;
            res.status = jfhs_pkg::ST_BAD_SIG;
          end
        end
        jfhs_pkg::PH_PREFIX: begin
          if (data_byte != jfhs_pkg::BYTE_FF) begin
            res.valid  = 1'b1;
            res.status = jfhs_pkg::ST_BAD_MRK;
          end
        end
        jfhs_pkg::PH_FRAME: begin
          if (cur_fidx > 3'd4) begin
            res.valid              = 1'b1;
            res.image_width        = cur_width;
            res.image_height       = cur_height;
            res.bits_per_component = cur_prec;
            res.component_count    = data_byte;
            unique case (data_byte)
              8'd1: res.color_space = jfhs_pkg::CS_GRAY;
              8'd3: res.color_space = jfhs_pkg::CS_RGB;
              8'd4: begin
                res.color_space   = jfhs_pkg::CS_CMYK;
                res.invert_decode = cur_seen;
              end
              default: res.status = jfhs_pkg::ST_BAD_COMP;
            endcase
          end
        end
        default: ;
      endcase
      // end of file without any other result
      if (!res.valid && last_byte) begin
        res.valid  = 1'b1;
        res.status = jfhs_pkg::ST_NO_FRAME;
      end
    end
  end

  // state registers, updated on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= jfhs_pkg::PH_SIG0;
      skip_r   <= '0;
      fidx_r   <= '0;
      lenhi_r  <= '0;
      code_r   <= '0;
      seen_r   <= 1'b0;
      match_r  <= 1'b0;
      height_r <= '0;
      width_r  <= '0;
      prec_r   <= '0;
      done_r   <= 1'b0;
    end else if (byte_acc) begin
      phase_r  <= phase_nxt;
      skip_r   <= skip_nxt;
      fidx_r   <= fidx_nxt;
      lenhi_r  <= lenhi_nxt;
      code_r   <= code_nxt;
      seen_r   <= seen_nxt;
      match_r  <= match_nxt;
      height_r <= height_nxt;
      width_r  <= width_nxt;
      prec_r   <= prec_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

>>> rtl/jpeg_frame_header_scanner_core.sv
// jpeg frame header scanner top level: byte parser plus result register
// Takes one file byte per cycle and returns one result per file: the frame
// header fields once the SOFn header is read, an error status at the first
// bad signature or marker prefix, or a no-frame status on the last byte.
// Each byte is parsed in the cycle it is accepted and any result appears
// on the out_ port in the next cycle. Throughput is one byte per clock; the
// input stalls only while a result sits in the output register and the
// downstream side holds out_stall.
`include "assert_macros.svh"

module jpeg_frame_header_scanner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [7:0]  out_bits_per_component,
  output logic [7:0]  out_component_count,
  output logic [1:0]  out_color_space,
  output logic        out_invert_decode
);

  jfhs_pkg::result_t res;
  jfhs_pkg::result_t out_r;
  logic              out_valid_r, out_valid_nxt;
  logic              in_acc;

  // input handshake
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  jfhs_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_acc   (in_acc),
    .data_byte  (in_data_byte),
    .first_byte (in_first_byte),
    .last_byte  (in_last_byte),
    .res        (res)
  );

  // output valid tracking
  always_comb begin
    priority if (res.valid) out_valid_nxt = 1'b1;
    else if (!out_stall)    out_valid_nxt = 1'b0;
    else                    out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_r.status;
  assign out_image_width        = out_r.image_width;
  assign out_image_height       = out_r.image_height;
  assign out_bits_per_component = out_r.bits_per_component;
  assign out_component_count    = out_r.component_count;
  assign out_color_space        = out_r.color_space;
  assign out_invert_decode      = out_r.invert_decode;

  // checks
  `ASSERT_IMPL(a_err_zero, out_valid && (out_status == jfhs_pkg::ST_BAD_SIG || out_status == jfhs_pkg::ST_BAD_MRK || out_status == jfhs_pkg::ST_NO_FRAME), out_image_width == 16'd0 && out_image_height == 16'd0 && out_component_count == 8'd0, "error result carries frame fields")
  `ASSERT_IMPL(a_invert_cmyk, out_valid && out_invert_decode, out_status == jfhs_pkg::ST_OK && out_component_count == 8'd4 && out_color_space == jfhs_pkg::CS_CMYK, "invert flag without four components")
  `ASSERT_IMPL(a_cs_range, out_valid, out_color_space != 2'd3, "color space code out of range")
  `ASSERT_NEXT(a_reset_empty, !rst_n, !out_valid, "result valid right after reset")

endmodule
